FILE: design/nsd_pkg.sv
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants for the nearest segment direction unit.
// ----------------------------------------------------------------------------
package nsd_pkg;

    localparam int COORD_W = 32;
    localparam int DELTA_W = 33;
    localparam int BOT_W   = 67;
    localparam int NUM_W   = 69;
    localparam int REM_W   = 68;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 68;
    localparam int E_W     = 53;
    localparam int EMAG_W  = 52;
    localparam int HALF_W  = 26;
    localparam int DIST_W  = 106;
    localparam int ROOT_W  = 34;
    localparam int T_W     = 17;
    localparam int DIRN_W  = 50;
    localparam int DIRQ_W  = 15;

    localparam logic [T_W-1:0]    T_ONE   = 17'd65536;
    localparam logic [DIRQ_W-1:0] DIR_ONE = 15'd16384;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FEW  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_BOT,
        ST_NUM,
        ST_TDEC,
        ST_DIV,
        ST_TD,
        ST_SQ,
        ST_CMP,
        ST_ROOT,
        ST_DIRI,
        ST_DIR,
        ST_DIRW
    } st_t;

endpackage

FILE: design/nsd_mul.sv
// ----------------------------------------------------------------------------
// nsd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module nsd_mul (
    input  logic                                clk,
    input  logic signed [nsd_pkg::MUL_W-1:0]    op_a,
    input  logic signed [nsd_pkg::MUL_W-1:0]    op_b,
    output logic signed [nsd_pkg::PROD_W-1:0]   prod
);

    logic signed [nsd_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: design/nsd_root.sv
// ----------------------------------------------------------------------------
// nsd_root
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nsd_root (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [nsd_pkg::BOT_W-1:0]           value,
    output logic                                busy,
    output logic [nsd_pkg::ROOT_W-1:0]          root
);

    localparam int V_W   = 2 * nsd_pkg::ROOT_W;
    localparam int R_W   = nsd_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(nsd_pkg::ROOT_W);

    logic [V_W-1:0]               v_reg;
    logic [R_W-1:0]               rem_reg;
    logic [nsd_pkg::ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         run_reg;
    logic [R_W-1:0]               rem_shift;
    logic [R_W-1:0]               trial;

    assign rem_shift = {rem_reg[R_W-3:0], v_reg[V_W-1 -: 2]};
    assign trial     = R_W'({root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(nsd_pkg::ROOT_W - 1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= V_W'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            v_reg <= v_reg << 2;
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[nsd_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[nsd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = run_reg;
    assign root = root_reg;

endmodule

FILE: design/nearest_segment_direction_unit.sv
// ----------------------------------------------------------------------------
// nearest_segment_direction_unit
// Polyline point table with a nearest segment search that returns the unit
// direction of the closest segment to a query point.
// ----------------------------------------------------------------------------
// Channel   Signals                                          Handshake
// input     opcode point_index coord_x coord_y coord_z       start & !busy
// config    cfg_data                                         cfg_we
// result    dir_x dir_y dir_z segment_index status           done, one cycle
//
// A load keeps busy low. A query keeps busy high while it steps through the
// segments on the shared multiplier, the bit-serial divide (skipped when the
// projection needs no division) and the bit-serial square root.
// Reset clears the control state only; table slots are undefined until loaded.
// The receiver cannot stall: each result is shown for the single done cycle.
// ----------------------------------------------------------------------------
module nearest_segment_direction_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                opcode,
    input  logic [5:0]          point_index,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_data,
    output logic                done,
    output logic signed [15:0]  dir_x,
    output logic signed [15:0]  dir_y,
    output logic signed [15:0]  dir_z,
    output logic [5:0]          segment_index,
    output logic [1:0]          status
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = AW + 1;
    localparam int PW  = 3 * nsd_pkg::COORD_W;

    nsd_pkg::st_t state_reg, state_next;

    logic [PW-1:0]   mem [MAX_POINTS];
    logic [PW-1:0]   rd_q_reg;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            mem_we;

    logic [6:0]      count_reg;
    logic [CW-1:0]   n_eff;
    logic            last_seg;
    logic            better;

    logic [1:0]      axis_reg, axis_next;
    logic            phase_reg, phase_next;
    logic [1:0]      part_reg, part_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [AW-1:0]   seg_reg, seg_next;
    logic            done_reg, done_next;

    logic signed [nsd_pkg::COORD_W-1:0]  q_reg [3];
    logic signed [nsd_pkg::COORD_W-1:0]  a_reg [3];
    logic signed [nsd_pkg::COORD_W-1:0]  b_reg [3];
    logic signed [nsd_pkg::DELTA_W-1:0]  d_c [3];
    logic signed [nsd_pkg::DELTA_W-1:0]  w_c [3];

    logic [nsd_pkg::BOT_W-1:0]           bot_reg;
    logic signed [nsd_pkg::NUM_W-1:0]    num_reg;
    logic [nsd_pkg::REM_W-1:0]           rem_reg;
    logic [nsd_pkg::REM_W-1:0]           rem_shift;
    logic [nsd_pkg::T_W-1:0]             t_reg;
    logic [nsd_pkg::EMAG_W-1:0]          emag_reg;
    logic signed [nsd_pkg::E_W-1:0]      e_c;
    logic [nsd_pkg::DIST_W-1:0]          dist_reg;
    logic [nsd_pkg::DIST_W-1:0]          best_dist_reg;
    logic [AW-1:0]                       best_reg;
    logic signed [nsd_pkg::DELTA_W-1:0]  bestd_reg [3];
    logic [nsd_pkg::BOT_W-1:0]           best_bot_reg;
    logic [nsd_pkg::ROOT_W-1:0]          m_reg;
    logic [nsd_pkg::DIRN_W-1:0]          dn_reg;
    logic [nsd_pkg::DIRN_W-1:0]          dsh_reg;
    logic [nsd_pkg::DIRQ_W-1:0]          dq_reg;
    logic [nsd_pkg::DIRQ_W-1:0]          dq_clamp;
    logic [nsd_pkg::DELTA_W-1:0]         dmag;

    logic signed [15:0]                  dir_reg [3];
    logic [5:0]                          segi_reg;
    logic [1:0]                          status_reg;

    logic signed [nsd_pkg::MUL_W-1:0]    mul_a, mul_b;
    logic signed [nsd_pkg::PROD_W-1:0]   prod;
    logic [nsd_pkg::PROD_W-1:0]          prod_u;
    logic                                num_pos;

    logic                                root_start;
    logic [nsd_pkg::BOT_W-1:0]           root_value;
    logic                                root_busy;
    logic [nsd_pkg::ROOT_W-1:0]          root;

    nsd_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    nsd_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (root_value),
        .busy  (root_busy),
        .root  (root)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_c[k] = nsd_pkg::DELTA_W'(b_reg[k]) - nsd_pkg::DELTA_W'(a_reg[k]);
            w_c[k] = nsd_pkg::DELTA_W'(q_reg[k]) - nsd_pkg::DELTA_W'(a_reg[k]);
        end
    end

    assign n_eff     = (int'(count_reg) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_reg);
    assign last_seg  = (CW'(seg_reg) + CW'(2)) == n_eff;
    assign better    = (seg_reg == '0) || (dist_reg < best_dist_reg);
    assign prod_u    = $unsigned(prod);
    assign num_pos   = !num_reg[nsd_pkg::NUM_W-1] && (num_reg != '0);
    assign rem_shift = {rem_reg[nsd_pkg::REM_W-2:0], 1'b0};
    assign e_c       = ((nsd_pkg::E_W'(a_reg[axis_reg]) - nsd_pkg::E_W'(q_reg[axis_reg])) <<< 16)
                       + nsd_pkg::E_W'(prod);
    assign root_value = better ? bot_reg : best_bot_reg;
    assign dmag      = bestd_reg[axis_reg][nsd_pkg::DELTA_W-1]
                       ? nsd_pkg::DELTA_W'(-bestd_reg[axis_reg])
                       : nsd_pkg::DELTA_W'(bestd_reg[axis_reg]);
    assign dq_clamp  = (dq_reg > nsd_pkg::DIR_ONE) ? nsd_pkg::DIR_ONE : dq_reg;
    assign wr_addr   = AW'(point_index);
    assign mem_we    = (state_reg == nsd_pkg::ST_IDLE) && start && (opcode == nsd_pkg::OP_LOAD)
                       && (int'(point_index) < MAX_POINTS);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            nsd_pkg::ST_BOT:
            begin
                mul_a = nsd_pkg::MUL_W'(d_c[axis_reg]);
                mul_b = nsd_pkg::MUL_W'(d_c[axis_reg]);
            end
            nsd_pkg::ST_NUM:
            begin
                mul_a = nsd_pkg::MUL_W'(w_c[axis_reg]);
                mul_b = nsd_pkg::MUL_W'(d_c[axis_reg]);
            end
            nsd_pkg::ST_TD:
            begin
                mul_a = $signed(nsd_pkg::MUL_W'(t_reg));
                mul_b = nsd_pkg::MUL_W'(d_c[axis_reg]);
            end
            nsd_pkg::ST_SQ:
            begin
                mul_a = (part_reg == 2'd2)
                        ? $signed(nsd_pkg::MUL_W'(emag_reg[nsd_pkg::HALF_W-1:0]))
                        : $signed(nsd_pkg::MUL_W'(emag_reg[nsd_pkg::EMAG_W-1 -: nsd_pkg::HALF_W]));
                mul_b = (part_reg == 2'd0)
                        ? $signed(nsd_pkg::MUL_W'(emag_reg[nsd_pkg::EMAG_W-1 -: nsd_pkg::HALF_W]))
                        : $signed(nsd_pkg::MUL_W'(emag_reg[nsd_pkg::HALF_W-1:0]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nsd_pkg::ST_IDLE;
            axis_reg  <= '0;
            phase_reg <= 1'b0;
            part_reg  <= '0;
            cnt_reg   <= '0;
            seg_reg   <= '0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            phase_reg <= phase_next;
            part_reg  <= part_next;
            cnt_reg   <= cnt_next;
            seg_reg   <= seg_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        phase_next = !phase_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        seg_next   = seg_reg;
        done_next  = 1'b0;
        rd_addr    = '0;
        root_start = 1'b0;
        case (state_reg)
            nsd_pkg::ST_IDLE:
            begin
                phase_next = 1'b0;
                if (start && (opcode == nsd_pkg::OP_QUERY))
                begin
                    if (n_eff < CW'(2))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        seg_next   = '0;
                        state_next = nsd_pkg::ST_FETCH_A;
                    end
                end
            end
            nsd_pkg::ST_FETCH_A:
            begin
                rd_addr    = AW'(1);
                state_next = nsd_pkg::ST_FETCH_B;
            end
            nsd_pkg::ST_FETCH_B:
            begin
                axis_next  = '0;
                phase_next = 1'b0;
                state_next = nsd_pkg::ST_BOT;
            end
            nsd_pkg::ST_BOT:
            begin
                if (phase_reg)
                begin
                    axis_next = axis_reg + 1'b1;
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = '0;
                        state_next = nsd_pkg::ST_NUM;
                    end
                end
            end
            nsd_pkg::ST_NUM:
            begin
                if (phase_reg)
                begin
                    axis_next = axis_reg + 1'b1;
                    if (axis_reg == 2'd1)
                    begin
                        axis_next  = '0;
                        state_next = nsd_pkg::ST_TDEC;
                    end
                end
            end
            nsd_pkg::ST_TDEC:
            begin
                phase_next = 1'b0;
                cnt_next   = '0;
                if ((bot_reg != '0) && num_pos
                    && ($unsigned(num_reg) < nsd_pkg::NUM_W'(bot_reg)))
                begin
                    state_next = nsd_pkg::ST_DIV;
                end
                else
                begin
                    state_next = nsd_pkg::ST_TD;
                end
            end
            nsd_pkg::ST_DIV:
            begin
                phase_next = 1'b0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = nsd_pkg::ST_TD;
                end
            end
            nsd_pkg::ST_TD:
            begin
                if (phase_reg)
                begin
                    part_next  = '0;
                    state_next = nsd_pkg::ST_SQ;
                end
            end
            nsd_pkg::ST_SQ:
            begin
                if (phase_reg)
                begin
                    part_next = part_reg + 1'b1;
                    if (part_reg == 2'd2)
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            state_next = nsd_pkg::ST_CMP;
                        end
                        else
                        begin
                            axis_next  = axis_reg + 1'b1;
                            state_next = nsd_pkg::ST_TD;
                        end
                    end
                end
            end
            nsd_pkg::ST_CMP:
            begin
                phase_next = 1'b0;
                if (last_seg)
                begin
                    root_start = 1'b1;
                    state_next = nsd_pkg::ST_ROOT;
                end
                else
                begin
                    seg_next   = seg_reg + 1'b1;
                    rd_addr    = AW'(CW'(seg_reg) + CW'(2));
                    state_next = nsd_pkg::ST_FETCH_B;
                end
            end
            nsd_pkg::ST_ROOT:
            begin
                axis_next = '0;
                if (!root_busy)
                begin
                    if (root == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = nsd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = nsd_pkg::ST_DIRI;
                    end
                end
            end
            nsd_pkg::ST_DIRI:
            begin
                cnt_next   = '0;
                state_next = nsd_pkg::ST_DIR;
            end
            nsd_pkg::ST_DIR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'(nsd_pkg::DIRQ_W - 1))
                begin
                    state_next = nsd_pkg::ST_DIRW;
                end
            end
            nsd_pkg::ST_DIRW:
            begin
                if (axis_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = nsd_pkg::ST_IDLE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = nsd_pkg::ST_DIRI;
                end
            end
            default:
            begin
                state_next = nsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {coord_z, coord_y, coord_x};
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            nsd_pkg::ST_IDLE:
            begin
                if (start && (opcode == nsd_pkg::OP_QUERY))
                begin
                    q_reg[0]   <= coord_x;
                    q_reg[1]   <= coord_y;
                    q_reg[2]   <= coord_z;
                    segi_reg   <= '0;
                    status_reg <= nsd_pkg::STAT_FEW;
                    for (int k = 0; k < 3; k++)
                    begin
                        dir_reg[k] <= '0;
                    end
                end
            end
            nsd_pkg::ST_FETCH_A:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    a_reg[k] <= rd_q_reg[k*nsd_pkg::COORD_W +: nsd_pkg::COORD_W];
                end
            end
            nsd_pkg::ST_FETCH_B:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    b_reg[k] <= rd_q_reg[k*nsd_pkg::COORD_W +: nsd_pkg::COORD_W];
                end
            end
            nsd_pkg::ST_BOT:
            begin
                if (phase_reg)
                begin
                    bot_reg <= ((axis_reg == 2'd0) ? '0 : bot_reg)
                               + nsd_pkg::BOT_W'(prod_u);
                end
            end
            nsd_pkg::ST_NUM:
            begin
                if (phase_reg)
                begin
                    num_reg <= ((axis_reg == 2'd0) ? '0 : num_reg) + nsd_pkg::NUM_W'(prod);
                end
            end
            nsd_pkg::ST_TDEC:
            begin
                dist_reg <= '0;
                rem_reg  <= nsd_pkg::REM_W'(num_reg);
                if ((bot_reg != '0) && num_pos)
                begin
                    t_reg <= nsd_pkg::T_ONE;
                    if ($unsigned(num_reg) < nsd_pkg::NUM_W'(bot_reg))
                    begin
                        t_reg <= '0;
                    end
                end
                else
                begin
                    t_reg <= '0;
                end
            end
            nsd_pkg::ST_DIV:
            begin
                if (rem_shift >= nsd_pkg::REM_W'(bot_reg))
                begin
                    rem_reg <= rem_shift - nsd_pkg::REM_W'(bot_reg);
                    t_reg   <= {t_reg[nsd_pkg::T_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    t_reg   <= {t_reg[nsd_pkg::T_W-2:0], 1'b0};
                end
            end
            nsd_pkg::ST_TD:
            begin
                if (phase_reg)
                begin
                    emag_reg <= e_c[nsd_pkg::E_W-1] ? nsd_pkg::EMAG_W'(-e_c)
                                                    : nsd_pkg::EMAG_W'(e_c);
                end
            end
            nsd_pkg::ST_SQ:
            begin
                if (phase_reg)
                begin
                    case (part_reg)
                        2'd0:    dist_reg <= dist_reg
                                             + (nsd_pkg::DIST_W'(prod_u) << (2 * nsd_pkg::HALF_W));
                        2'd1:    dist_reg <= dist_reg
                                             + (nsd_pkg::DIST_W'(prod_u) << (nsd_pkg::HALF_W + 1));
                        default: dist_reg <= dist_reg + nsd_pkg::DIST_W'(prod_u);
                    endcase
                end
            end
            nsd_pkg::ST_CMP:
            begin
                if (better)
                begin
                    best_reg      <= seg_reg;
                    best_dist_reg <= dist_reg;
                    best_bot_reg  <= bot_reg;
                    for (int k = 0; k < 3; k++)
                    begin
                        bestd_reg[k] <= d_c[k];
                    end
                end
                for (int k = 0; k < 3; k++)
                begin
                    a_reg[k] <= b_reg[k];
                end
            end
            nsd_pkg::ST_ROOT:
            begin
                m_reg      <= root;
                segi_reg   <= 6'(best_reg);
                status_reg <= (root == '0) ? nsd_pkg::STAT_ZERO : nsd_pkg::STAT_OK;
            end
            nsd_pkg::ST_DIRI:
            begin
                dn_reg  <= (nsd_pkg::DIRN_W'(dmag) << 15) + nsd_pkg::DIRN_W'(m_reg);
                dsh_reg <= nsd_pkg::DIRN_W'(m_reg) << 15;
                dq_reg  <= '0;
            end
            nsd_pkg::ST_DIR:
            begin
                dsh_reg <= dsh_reg >> 1;
                if (dn_reg >= dsh_reg)
                begin
                    dn_reg <= dn_reg - dsh_reg;
                    dq_reg <= {dq_reg[nsd_pkg::DIRQ_W-2:0], 1'b1};
                end
                else
                begin
                    dq_reg <= {dq_reg[nsd_pkg::DIRQ_W-2:0], 1'b0};
                end
            end
            nsd_pkg::ST_DIRW:
            begin
                dir_reg[axis_reg] <= bestd_reg[axis_reg][nsd_pkg::DELTA_W-1]
                                     ? -$signed(16'(dq_clamp)) : $signed(16'(dq_clamp));
            end
            default:
            begin
            end
        endcase
    end

    assign busy          = (state_reg != nsd_pkg::ST_IDLE);
    assign done          = done_reg;
    assign dir_x         = dir_reg[0];
    assign dir_y         = dir_reg[1];
    assign dir_z         = dir_reg[2];
    assign segment_index = segi_reg;
    assign status        = status_reg;

    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == nsd_pkg::STAT_OK || status == nsd_pkg::STAT_FEW
                  || status == nsd_pkg::STAT_ZERO))
        else $error("Result carries an unknown status code.");

    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != nsd_pkg::STAT_OK)) |-> (dir_x == 0 && dir_y == 0 && dir_z == 0))
        else $error("Error result carries a nonzero direction.");

    a_busy_query : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && ($past(opcode) == nsd_pkg::OP_QUERY)))
        else $error("Block went busy without an accepted query item.");

endmodule

FILE: dv/nearest_segment_direction_unit_tb.sv
// ----------------------------------------------------------------------------
// nearest_segment_direction_unit_tb
// Loads polylines into the point table and fires queries at them. A built-in
// predictor works out the nearest segment and its unit direction for every
// accepted query with no preset result. Each result is checked field by
// field against the oldest expected result. Random gaps on the sender side
// and several point_count settings, the extremes among them, are used.
// ----------------------------------------------------------------------------
module nearest_segment_direction_unit_tb;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [5:0]         seg;
        logic [1:0]         stat;
    } seg_result_t;

    typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               op;
        logic [5:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 has_exp;
        seg_result_t        exp;
    } row_t;

    localparam int IDLE_LIMIT  = 20000;
    localparam int ITEM_TARGET = 700;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               opcode;
    logic [5:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               cfg_we;
    logic [6:0]         cfg_data;
    logic               done;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [5:0]         segment_index;
    logic [1:0]         status;

    longint      shadow_pts[64][3];
    logic [6:0]  shadow_count;
    seg_result_t pending_dirs[$];
    int          fail_count;
    int          items_sent;
    int          idle_cycles;
    row_t        directed[$];

    nearest_segment_direction_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .point_index   (point_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .segment_index (segment_index),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic wide_t seg_dist_sq(int a, longint q[3]);
        wide_t w[3];
        wide_t pa[3];
        wide_t wq[3];
        wide_t bot;
        wide_t num;
        wide_t t;
        wide_t e;
        wide_t acc;
        for (int k = 0; k < 3; k++)
        begin
            w[k]  = shadow_pts[a+1][k] - shadow_pts[a][k];
            pa[k] = shadow_pts[a][k];
            wq[k] = q[k];
        end
        bot = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
        num = (wq[0] - pa[0]) * w[0] + (wq[1] - pa[1]) * w[1];
        t = 0;
        if (bot != 0 && num > 0)
            t = (num >= bot) ? wide_t'(65536) : (num <<< 16) / bot;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            e = (pa[k] - wq[k]) * 65536 + t * w[k];
            acc = acc + e * e;
        end
        return acc;
    endfunction

    function automatic longint root_floor(wide_t v);
        wide_t r;
        wide_t c;
        r = 0;
        for (int b = 34; b >= 0; b--)
        begin
            c = r | (wide_t'(1) <<< b);
            if (c * c <= v)
                r = c;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [15:0] unit_comp(longint d, longint m);
        longint a;
        longint q;
        a = (d < 0) ? -d : d;
        q = (a * 2 * 16384 + m) / (2 * m);
        if (q > 16384)
            q = 16384;
        return (d < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic seg_result_t nearest_direction(longint q[3]);
        seg_result_t r;
        int          n;
        int          best;
        wide_t       best_d;
        wide_t       dd;
        longint      d[3];
        longint      m;
        r = '{dx: 0, dy: 0, dz: 0, seg: 0, stat: nsd_pkg::STAT_OK};
        n = (shadow_count > 64) ? 64 : int'(shadow_count);
        if (n < 2)
        begin
            r.stat = nsd_pkg::STAT_FEW;
            return r;
        end
        best = 0;
        best_d = 0;
        for (int i = 0; i + 1 < n; i++)
        begin
            dd = seg_dist_sq(i, q);
            if (i == 0 || dd < best_d)
            begin
                best = i;
                best_d = dd;
            end
        end
        r.seg = 6'(best);
        for (int k = 0; k < 3; k++)
            d[k] = shadow_pts[best+1][k] - shadow_pts[best][k];
        m = root_floor(wide_t'(d[0]) * d[0] + wide_t'(d[1]) * d[1] + wide_t'(d[2]) * d[2]);
        if (m == 0)
        begin
            r.stat = nsd_pkg::STAT_ZERO;
            return r;
        end
        r.dx = unit_comp(d[0], m);
        r.dy = unit_comp(d[1], m);
        r.dz = unit_comp(d[2], m);
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord(logic signed [31:0] prev);
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            3: v = prev;
            default: v = (int'($urandom_range(0, 16)) - 8) * 65536
                         + int'($urandom_range(0, 3)) * 16384;
        endcase
        return v;
    endfunction

    function automatic row_t mk_item(logic op, logic [5:0] idx, logic signed [31:0] x,
                                     logic signed [31:0] y, logic signed [31:0] z);
        row_t r;
        r = '{kind: ROW_ITEM, op: op, idx: idx, x: x, y: y, z: z, has_exp: 1'b0,
              exp: '{dx: 0, dy: 0, dz: 0, seg: 0, stat: nsd_pkg::STAT_OK}};
        return r;
    endfunction

    function automatic row_t mk_cfg(logic [6:0] v);
        row_t r;
        r = mk_item(nsd_pkg::OP_LOAD, 0, 0, 0, 0);
        r.kind = ROW_CFG;
        r.idx = 6'(v);
        r.x = v;
        return r;
    endfunction

    function automatic row_t with_exp(row_t r, logic signed [15:0] dx, logic signed [15:0] dy,
                                      logic signed [15:0] dz, logic [5:0] seg,
                                      logic [1:0] stat);
        r.has_exp = 1'b1;
        r.exp = '{dx: dx, dy: dy, dz: dz, seg: seg, stat: stat};
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_dirs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_count(logic [6:0] v);
        wait_drained();
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        shadow_count = v;
    endtask

    task automatic issue(row_t r, int gap);
        longint q[3];
        repeat (gap) @(negedge clk);
        start = 1'b1;
        opcode = r.op;
        point_index = r.idx;
        coord_x = r.x;
        coord_y = r.y;
        coord_z = r.z;
        do
            @(posedge clk);
        while (busy);
        q[0] = r.x;
        q[1] = r.y;
        q[2] = r.z;
        if (r.op == nsd_pkg::OP_LOAD)
            shadow_pts[r.idx] = q;
        else
            pending_dirs.push_back(r.has_exp ? r.exp : nearest_direction(q));
        items_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    always @(posedge clk)
    begin
        seg_result_t e;
        if (rst_n && done)
        begin
            if (pending_dirs.size() == 0)
            begin
                $error("result with no expected item pending");
                fail_count++;
            end
            else
            begin
                e = pending_dirs.pop_front();
                if (dir_x !== e.dx)
                begin
                    $error("dir_x expected %0d actual %0d", e.dx, dir_x);
                    fail_count++;
                end
                if (dir_y !== e.dy)
                begin
                    $error("dir_y expected %0d actual %0d", e.dy, dir_y);
                    fail_count++;
                end
                if (dir_z !== e.dz)
                begin
                    $error("dir_z expected %0d actual %0d", e.dz, dir_z);
                    fail_count++;
                end
                if (segment_index !== e.seg)
                begin
                    $error("segment_index expected %0d actual %0d", e.seg, segment_index);
                    fail_count++;
                end
                if (status !== e.stat)
                begin
                    $error("status expected %0d actual %0d", e.stat, status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || cfg_we || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;
        int loads;
        int queries;
        int gap;
        bit no_gaps;
        row_t r;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;

        rst_n = 1'b0;
        start = 1'b0;
        opcode = nsd_pkg::OP_LOAD;
        point_index = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        items_sent = 0;
        shadow_count = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed.push_back(with_exp(mk_item(nsd_pkg::OP_QUERY, 6'h3f, 0, 0, 0), 0, 0, 0, 0,
                                    nsd_pkg::STAT_FEW));
        directed.push_back(mk_cfg(1));
        directed.push_back(with_exp(mk_item(nsd_pkg::OP_QUERY, 0, 32'sh10000, 5, -7),
                                    0, 0, 0, 0, nsd_pkg::STAT_FEW));
        directed.push_back(mk_item(nsd_pkg::OP_LOAD, 0, 0, 0, 0));
        directed.push_back(mk_item(nsd_pkg::OP_LOAD, 1, 32'sh10000, 0, 0));
        directed.push_back(mk_item(nsd_pkg::OP_LOAD, 2, 32'sh10000, 32'sh10000, 0));
        directed.push_back(mk_cfg(3));
        directed.push_back(with_exp(mk_item(nsd_pkg::OP_QUERY, 0, 32'sh8000, -32'sh10000, 0),
                                    16384, 0, 0, 0, nsd_pkg::STAT_OK));
        directed.push_back(with_exp(mk_item(nsd_pkg::OP_QUERY, 0, 32'sh20000, 32'sh20000, 0),
                                    0, 16384, 0, 1, nsd_pkg::STAT_OK));
        directed.push_back(mk_item(nsd_pkg::OP_LOAD, 3, 32'sh7fffffff, 32'sh7fffffff,
                                   32'sh7fffffff));
        directed.push_back(mk_item(nsd_pkg::OP_LOAD, 4, 32'sh80000000, 32'sh80000000,
                                   32'sh80000000));
        directed.push_back(mk_item(nsd_pkg::OP_LOAD, 5, 32'sh80000000, 32'sh80000000,
                                   32'sh80000000));
        directed.push_back(mk_item(nsd_pkg::OP_LOAD, 6, 0, 0, 32'sh10000));
        directed.push_back(mk_cfg(7));
        directed.push_back(mk_item(nsd_pkg::OP_QUERY, 0, 32'sh80000000, 32'sh80000000,
                                   32'sh80000000));
        directed.push_back(mk_item(nsd_pkg::OP_QUERY, 0, 32'sh7fffffff, 32'sh7fffffff,
                                   32'sh7fffffff));
        directed.push_back(mk_item(nsd_pkg::OP_QUERY, 0, 0, 0, 32'sh8000));
        directed.push_back(mk_item(nsd_pkg::OP_QUERY, 0, 0, 0, 0));
        directed.push_back(mk_item(nsd_pkg::OP_QUERY, 0, 32'sh10000, 32'sh8000, 32'sh70000));
        directed.push_back(mk_cfg(2));
        directed.push_back(mk_item(nsd_pkg::OP_QUERY, 0, -1, -1, -1));

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_count(7'(directed[i].x));
            else
                issue(directed[i], $urandom_range(0, 3));
        end

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 19))
                0: n = $urandom_range(0, 1);
                1: n = 64;
                2: n = 127;
                3: n = $urandom_range(65, 126);
                4, 5: n = $urandom_range(9, 20);
                default: n = $urandom_range(2, 8);
            endcase
            write_count(7'(n));
            no_gaps = ($urandom_range(0, 3) == 0);
            loads = (n > 64) ? 64 : n;
            px = 0;
            py = 0;
            pz = 0;
            for (int s = 0; s < loads; s++)
            begin
                if ($urandom_range(0, 7) != 0)
                begin
                    px = rand_coord(px);
                    py = rand_coord(py);
                    pz = rand_coord(pz);
                end
                gap = no_gaps ? 0 : $urandom_range(0, 19);
                issue(mk_item(nsd_pkg::OP_LOAD, 6'(s), px, py, pz), gap);
            end
            queries = $urandom_range(2, 12);
            for (int j = 0; j < queries; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
                gap = no_gaps ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 6) == 0)
                begin
                    r = mk_item(nsd_pkg::OP_LOAD, 6'($urandom_range(0, 63)), $urandom,
                                $urandom, $urandom);
                    if (r.idx >= loads)
                    begin
                        r.x = rand_coord(0);
                        r.y = rand_coord(0);
                        r.z = rand_coord(0);
                    end
                end
                else
                    r = mk_item(nsd_pkg::OP_QUERY, 6'($urandom_range(0, 63)), rand_coord(px),
                                rand_coord(py), rand_coord(pz));
                issue(r, gap);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/nsd_pkg.sv
design/nsd_mul.sv
design/nsd_root.sv
design/nearest_segment_direction_unit.sv
dv/nearest_segment_direction_unit_tb.sv
